/* rtl/eemrx_pkg.sv */
package eemrx_pkg;

    localparam int unsigned MIN_FRAME = 18;
    localparam int unsigned FCS_BYTES = 4;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned QDEPTH    = 4;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_SENTRY  = 32'hDEAD_BEEF;
    localparam logic [2:0]  CMD_ECHO    = 3'd0;
    localparam logic [2:0]  CMD_SUSPEND = 3'd2;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_GOOD    = 3'd1,
        K_BAD     = 3'd2,
        K_ABORT   = 3'd3,
        K_EBYTE   = 3'd4,
        K_EDONE   = 3'd5,
        K_EABORT  = 3'd6,
        K_SUSPEND = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        PH_LO   = 5'b00001,
        PH_HI   = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SKIP = 5'b01000,
        PH_ECHO = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/eem_receive_deframer_top.sv */
// Receive-side deframer for CDC EEM bundles.
// Slave channel: one transfer byte per request, tlast marks the final byte
// of a USB transfer. Master channel: one result per request, tdata is the
// payload or echo byte, tuser the result kind, tlast the final result
// raised by one input byte.
// Each accepted byte is decoded in the cycle it is accepted; its results
// (none to three) are registered into a four-entry result queue and leave
// it in order on the master side, one per cycle while m_tready is high.
// Throughput is one byte per cycle while each byte raises at most one
// result and m_tready stays high; a byte that raises two or three results
// holds s_tready low for the extra cycles the queue needs to drain.
// s_tready is high while the queue holds at most one result.
// Reset clears the queue and returns the deframer to waiting for a header.
// A stalled receiver lets the queue fill; s_tready drops once it holds more
// than one result, which leaves room for any byte's results: nothing is lost.
module eem_receive_deframer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // transfer_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [7:0] m_tuser,   // [2:0] kind, zero fill above
    output logic       m_tlast    // run_last
);

    localparam int unsigned QW = $clog2(eemrx_pkg::QDEPTH);
    localparam int unsigned CW = $clog2(eemrx_pkg::QDEPTH + 1);

    eemrx_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  header_low_reg, header_low_next;
    logic [13:0] bytes_left_reg, bytes_left_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic        crc_flag_reg, crc_flag_next;

    eemrx_pkg::result_t queue_reg [eemrx_pkg::QDEPTH];
    logic [QW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;

    eemrx_pkg::result_t res [eemrx_pkg::MAX_RES];
    logic [1:0]  nres;
    logic        accept, pop;
    logic [15:0] hdr;
    logic [13:0] bl_dec;
    logic [1:0]  idx;
    logic [10:0] elen;
    logic        ok;

    assign s_tready = count_reg <= CW'(eemrx_pkg::QDEPTH - eemrx_pkg::MAX_RES);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = queue_reg[head_reg].data;
    assign m_tuser  = {5'd0, queue_reg[head_reg].kind};
    assign m_tlast  = queue_reg[head_reg].last;

    assign hdr    = {s_tdata, header_low_reg};
    assign bl_dec = bytes_left_reg - 14'd1;
    assign idx    = 2'd0 - bytes_left_reg[1:0];
    assign elen   = hdr[10:0];

    always_comb begin
        phase_next        = phase_reg;
        header_low_next   = header_low_reg;
        bytes_left_next   = bytes_left_reg;
        crc_accum_next    = crc_accum_reg;
        received_crc_next = received_crc_reg;
        crc_flag_next     = crc_flag_reg;
        nres              = 2'd0;
        ok                = 1'b0;
        for (int i = 0; i < eemrx_pkg::MAX_RES; i++) begin
            res[i] = '{kind: eemrx_pkg::K_BYTE, data: 8'd0, last: 1'b0};
        end

        case (phase_reg)
            eemrx_pkg::PH_HI: begin
                phase_next = eemrx_pkg::PH_LO;
                if (hdr[15]) begin
                    if (!hdr[14]) begin
                        if (hdr[13:11] == eemrx_pkg::CMD_ECHO) begin
                            res[0] = '{kind: eemrx_pkg::K_EBYTE, data: elen[7:0], last: 1'b0};
                            res[1] = '{kind: eemrx_pkg::K_EBYTE,
                                       data: {5'b10001, elen[10:8]}, last: 1'b0};
                            nres = 2'd2;
                            if (elen == '0) begin
                                res[2].kind = eemrx_pkg::K_EDONE;
                                nres = 2'd3;
                            end else if (s_tlast) begin
                                res[2].kind = eemrx_pkg::K_EABORT;
                                nres = 2'd3;
                            end else begin
                                bytes_left_next = {3'd0, elen};
                                phase_next      = eemrx_pkg::PH_ECHO;
                            end
                        end else if (hdr[13:11] == eemrx_pkg::CMD_SUSPEND) begin
                            res[0].kind = eemrx_pkg::K_SUSPEND;
                            nres = 2'd1;
                        end
                    end
                end else if (hdr != 16'd0) begin
                    if (hdr[13:0] < 14'(eemrx_pkg::MIN_FRAME)) begin
                        if (hdr[13:0] != '0 && !s_tlast) begin
                            bytes_left_next = hdr[13:0];
                            phase_next      = eemrx_pkg::PH_SKIP;
                        end
                    end else if (s_tlast) begin
                        res[0].kind = eemrx_pkg::K_ABORT;
                        nres = 2'd1;
                    end else begin
                        bytes_left_next   = hdr[13:0];
                        crc_flag_next     = hdr[14];
                        crc_accum_next    = eemrx_pkg::CRC_INIT;
                        received_crc_next = '0;
                        phase_next        = eemrx_pkg::PH_DATA;
                    end
                end
            end
            eemrx_pkg::PH_DATA: begin
                if (bytes_left_reg > 14'(eemrx_pkg::FCS_BYTES)) begin
                    res[0] = '{kind: eemrx_pkg::K_BYTE, data: s_tdata, last: 1'b0};
                    nres = 2'd1;
                    crc_accum_next = eemrx_pkg::crc_byte(crc_accum_reg, s_tdata);
                end else if (crc_flag_reg) begin
                    received_crc_next = received_crc_reg | ({24'd0, s_tdata} << {idx, 3'b000});
                end else begin
                    received_crc_next = {received_crc_reg[23:0], s_tdata};
                end
                bytes_left_next = bl_dec;
                if (bl_dec == '0) begin
                    ok = crc_flag_reg ? (~crc_accum_reg == received_crc_next)
                                      : (received_crc_next == eemrx_pkg::CRC_SENTRY);
                    res[nres].kind = ok ? eemrx_pkg::K_GOOD : eemrx_pkg::K_BAD;
                    nres = nres + 2'd1;
                    phase_next = eemrx_pkg::PH_LO;
                end else if (s_tlast) begin
                    res[nres].kind = eemrx_pkg::K_ABORT;
                    nres = nres + 2'd1;
                end
            end
            eemrx_pkg::PH_ECHO: begin
                res[0] = '{kind: eemrx_pkg::K_EBYTE, data: s_tdata, last: 1'b0};
                bytes_left_next = bl_dec;
                if (bl_dec == '0) begin
                    res[1].kind = eemrx_pkg::K_EDONE;
                    nres = 2'd2;
                    phase_next = eemrx_pkg::PH_LO;
                end else if (s_tlast) begin
                    res[1].kind = eemrx_pkg::K_EABORT;
                    nres = 2'd2;
                end else begin
                    nres = 2'd1;
                end
            end
            eemrx_pkg::PH_SKIP: begin
                bytes_left_next = bl_dec;
                if (bl_dec == '0) begin
                    phase_next = eemrx_pkg::PH_LO;
                end
            end
            default: begin
                header_low_next = s_tdata;
                phase_next      = eemrx_pkg::PH_HI;
            end
        endcase

        if (s_tlast) begin
            phase_next = eemrx_pkg::PH_LO;
        end
        if (nres != 2'd0) begin
            res[nres - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= eemrx_pkg::PH_LO;
            header_low_reg   <= '0;
            bytes_left_reg   <= '0;
            crc_accum_reg    <= eemrx_pkg::CRC_INIT;
            received_crc_reg <= '0;
            crc_flag_reg     <= 1'b0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            header_low_reg   <= header_low_next;
            bytes_left_reg   <= bytes_left_next;
            crc_accum_reg    <= crc_accum_next;
            received_crc_reg <= received_crc_next;
            crc_flag_reg     <= crc_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < eemrx_pkg::MAX_RES; i++) begin
                if (2'(i) < nres) begin
                    queue_reg[QW'(tail_reg + QW'(i))] <= res[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (pop) begin
                head_reg <= head_reg + QW'(1);
            end
            if (accept) begin
                tail_reg <= tail_reg + QW'(nres);
            end
            count_reg <= count_reg + (accept ? CW'(nres) : CW'(0)) - CW'(pop);
        end
    end

endmodule
